>>> hdl/sfr_pkg.sv
// Shared types and constants for the sensor frame receiver with CRC-16.
// No dependencies; imported by every module of the block except sfr_crc_step.
`default_nettype none

package sfr_pkg;

  // Frame layout
  localparam int unsigned FrameBytes   = 40;
  localparam int unsigned PayloadWords = 9;
  localparam int unsigned PosWidth     = 6;

  localparam logic [PosWidth-1:0] PosHunt    = 6'd0;
  localparam logic [PosWidth-1:0] PosLastPay = PosWidth'(FrameBytes - 4);
  localparam logic [PosWidth-1:0] PosCrcLow  = PosWidth'(FrameBytes - 3);
  localparam logic [PosWidth-1:0] PosCrcHigh = PosWidth'(FrameBytes - 2);
  localparam logic [PosWidth-1:0] PosTail    = PosWidth'(FrameBytes - 1);

  localparam logic [7:0] HeaderByte = 8'hA5;
  localparam logic [7:0] TailByte   = 8'hB2;

  // Configuration register indexes
  localparam logic CfgIdxPoly = 1'b0;
  localparam logic CfgIdxInit = 1'b1;

  localparam logic [15:0] PolyReset = 16'h8408;
  localparam logic [15:0] InitReset = 16'hFFFF;

  // Payload words that leave with bit 31 inverted: gyro x,y and accel x,y
  localparam logic [PayloadWords-1:0] SignFlipMask = 9'b0_0001_1011;

  localparam int unsigned OutDataBits = 296;

  typedef struct packed {
    logic [PayloadWords-1:0][31:0] words;
    logic [1:0]                    status;
  } frame_result_t;

endpackage

`default_nettype wire

>>> hdl/sfr_crc_step.sv
// One byte of a reflected, table-style CRC-16 update, table entry built on the fly.
// Does not use sfr_pkg; purely combinational.
`default_nettype none

module sfr_crc_step (
  input  logic [15:0] crc_i,
  input  logic [7:0]  byte_i,
  input  logic [15:0] poly_i,
  output logic [15:0] crc_o
);

  always_comb begin
    logic [15:0] t;
    t = {8'h00, crc_i[7:0] ^ byte_i};
    for (int i = 0; i < 8; i++) begin
      t = t[0] ? ((t >> 1) ^ poly_i) : (t >> 1);
    end
    crc_o = {8'h00, crc_i[15:8]} ^ t;
  end

endmodule

`default_nettype wire

>>> hdl/sfr_deframer.sv
// Frame tracker: header hunt, byte position, CRC, payload store and status.
// Depends on sfr_pkg and sfr_crc_step.
`default_nettype none

module sfr_deframer (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [7:0]            byte_i,
  input  logic [15:0]           poly_i,
  input  logic [15:0]           init_i,
  output logic                  at_tail_o,
  output logic                  res_valid_o,
  output sfr_pkg::frame_result_t res_o
);
  import sfr_pkg::*;

  logic [PosWidth-1:0] pos_q, pos_d;
  logic [15:0]         crc_q, crc_d, crc_next, crc_src;
  logic [7:0]          crc_low_q, crc_low_d;
  logic                mismatch_q, mismatch_d;
  logic [PayloadWords-1:0][31:0] payload_q;
  logic [PosWidth-1:0] rel;

  assign crc_src = (pos_q == PosHunt) ? init_i : crc_q;
  assign rel     = pos_q - PosWidth'(1);

  sfr_crc_step u_crc_step (
    .crc_i  (crc_src),
    .byte_i (byte_i),
    .poly_i (poly_i),
    .crc_o  (crc_next)
  );

  always_comb begin
    pos_d      = pos_q;
    crc_d      = crc_q;
    crc_low_d  = crc_low_q;
    mismatch_d = mismatch_q;
    if (accept_i) begin
      if (pos_q == PosHunt) begin
        if (byte_i == HeaderByte) begin
          crc_d = crc_next;
          pos_d = PosWidth'(1);
        end
      end else if (pos_q <= PosLastPay) begin
        crc_d = crc_next;
        pos_d = pos_q + PosWidth'(1);
      end else if (pos_q == PosCrcLow) begin
        crc_low_d = byte_i;
        pos_d     = pos_q + PosWidth'(1);
      end else if (pos_q == PosCrcHigh) begin
        mismatch_d = (crc_low_q != crc_q[7:0]) || (byte_i != crc_q[15:8]);
        pos_d      = pos_q + PosWidth'(1);
      end else begin
        pos_d      = PosHunt;
        mismatch_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= PosHunt;
      crc_q      <= 16'h0000;
      crc_low_q  <= 8'h00;
      mismatch_q <= 1'b0;
    end else begin
      pos_q      <= pos_d;
      crc_q      <= crc_d;
      crc_low_q  <= crc_low_d;
      mismatch_q <= mismatch_d;
    end
  end

  // Store payload bytes little-endian, one byte lane per accepted word
  always_ff @(posedge clk_i) begin
    if (accept_i && (pos_q != PosHunt) && (pos_q <= PosLastPay)) begin
      for (int w = 0; w < PayloadWords; w++) begin
        if (rel[PosWidth-1:2] == 4'(w)) begin
          payload_q[w][rel[1:0]*8 +: 8] <= byte_i;
        end
      end
    end
  end

  assign at_tail_o   = (pos_q == PosTail);
  assign res_valid_o = accept_i && at_tail_o;

  always_comb begin
    res_o.status = {byte_i != TailByte, mismatch_q};
    for (int k = 0; k < PayloadWords; k++) begin
      res_o.words[k] = payload_q[k] ^ {SignFlipMask[k], 31'h0};
    end
  end

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosTail)
    else $error("byte position past end of frame");

  a_hunt_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && (pos_q == PosHunt) && (byte_i != HeaderByte) |=> pos_q == PosHunt)
    else $error("left hunting without a header");

  a_tail_rearm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && (pos_q == PosTail) |=> (pos_q == PosHunt) && !mismatch_q)
    else $error("frame end did not rearm the hunt");

endmodule

`default_nettype wire

>>> hdl/sfr_out_reg.sv
// Result holding register for the master stream side.
// Depends on sfr_pkg.
`default_nettype none

module sfr_out_reg (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  sfr_pkg::frame_result_t in_res_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output sfr_pkg::frame_result_t out_res_o
);
  import sfr_pkg::*;

  logic          valid_q;
  frame_result_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_valid_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i) begin
      res_q <= in_res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_res_o   = res_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_valid_i && valid_q && !out_ready_i))
    else $error("result overwritten before it was taken");

endmodule

`default_nettype wire

>>> hdl/sensor_frame_receiver_crc16_core.sv
// Sensor frame receiver: top level with configuration registers and stream ports.
// Depends on sfr_pkg, sfr_deframer (with sfr_crc_step) and sfr_out_reg.
`default_nettype none

// Takes one received serial byte per word on the slave stream. While hunting it
// drops bytes until the header 0xA5, then collects a 40-byte frame, runs a
// reflected CRC-16 over bytes 0..36, checks it against bytes 37 (low) and 38
// (high), and checks the tail 0xB2 at byte 39. At the tail byte it emits one
// word carrying a 2-bit status (bit0 CRC mismatch, bit1 tail wrong) and the
// nine little-endian payload words, gyro and accel x,y with bit 31 inverted.
// Bad frames are still delivered; only the status flags them. A header inside
// a frame is plain data. Rate: one byte per clock unless a tail byte is held
// off; the CRC byte update and the position counter are registered per byte.
// The result appears on the master side in the cycle after the tail byte is
// accepted and waits there in its own register, so bytes of the next frame keep
// flowing; only a tail byte that arrives while the previous result is still
// untaken is held off. Writes to the polynomial apply from the next byte,
// writes to the initial value at the next header.
module sensor_frame_receiver_crc16_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  // configuration write port
  input  logic         cfg_we_i,
  input  logic         cfg_index_i,
  input  logic [15:0]  cfg_wdata_i,
  // slave stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // rx_byte[7:0]
  // master stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [295:0] m_axis_tdata    // frame_status[1:0], gyro_x, gyro_y, gyro_z,
                                        // accel_x, accel_y, accel_z, speed_x,
                                        // speed_y, turn_rate (32 bits each), zero pad
);
  import sfr_pkg::*;

  logic [15:0]   poly_q, init_q;
  logic          accept;
  logic          at_tail;
  logic          res_valid;
  frame_result_t res;
  frame_result_t out_res;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q <= PolyReset;
      init_q <= InitReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgIdxPoly: poly_q <= cfg_wdata_i;
        CfgIdxInit: init_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Hold off only a tail byte that would need an occupied result register
  assign s_axis_tready = !(at_tail && m_axis_tvalid && !m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;

  sfr_deframer u_deframer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .byte_i      (s_axis_tdata),
    .poly_i      (poly_q),
    .init_i      (init_q),
    .at_tail_o   (at_tail),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  sfr_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (res_valid),
    .in_res_i    (res),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_res_o   (out_res)
  );

  // Pack status in the lowest bits, then the nine words, zero fill to bytes
  assign m_axis_tdata = {{(OutDataBits - $bits(frame_result_t)){1'b0}}, out_res};

  a_tail_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && at_tail |=> m_axis_tvalid)
    else $error("tail byte accepted but no result shown");

  a_stall_only_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> at_tail && m_axis_tvalid)
    else $error("input stalled outside a pending tail byte");

endmodule

`default_nettype wire

>>> sim/tb_sensor_frame_receiver_crc16_core.sv
// Self-checking testbench for sensor_frame_receiver_crc16_core: framed serial bytes in,
// one status-plus-payload word out per frame, compared against an in-bench deframer model.
// Depends on sfr_pkg and the core RTL only.
`default_nettype none

module tb_sensor_frame_receiver_crc16_core;
  timeunit 1ns;
  timeprecision 1ps;

  import sfr_pkg::*;

  localparam int unsigned ResBits  = $bits(frame_result_t);
  localparam int unsigned HoldOff  = 400;   // receiver back-pressure stretch, in cycles
  localparam int unsigned MaxPrint = 50;

  // Frame status codes as delivered in the low bits of the result word
  localparam logic [1:0] StatusGood    = 2'd0;
  localparam logic [1:0] StatusCrcBad  = 2'd1;
  localparam logic [1:0] StatusTailBad = 2'd2;
  localparam logic [1:0] StatusBothBad = 2'd3;

  typedef enum logic [2:0] {
    FillZero, FillOnes, FillRamp, FillHeader, FillTail, FillRandom
  } fill_e;

  typedef enum logic [1:0] {CrcKeep, CrcBadLow, CrcBadHigh, CrcBadBoth} crc_fault_e;

  // One directed frame: noise bytes ahead of it, payload pattern, CRC damage,
  // tail byte, and a status typed in by hand where it is plain to see.
  typedef struct packed {
    logic [2:0] lead;
    fill_e      fill;
    crc_fault_e fault;
    logic [7:0] tail;
    bit         typed;
    logic [1:0] status;
  } frame_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic                   cfg_index_i = CfgIdxPoly;
  logic [15:0]            cfg_wdata_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [7:0]             s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OutDataBits-1:0] m_axis_tdata;

  sensor_frame_receiver_crc16_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // rx_byte[7:0]
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)    // frame_status[1:0], then nine 32-bit payload words
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Deframer model: its own copy of the configuration and the frame state.
  // ---------------------------------------------------------------------------
  logic [15:0] crc_poly = PolyReset;
  logic [15:0] crc_seed = InitReset;
  logic [5:0]  rx_pos = PosHunt;
  logic [15:0] rx_crc = '0;
  logic [7:0]  rx_crc_low = '0;
  bit          rx_crc_bad = 1'b0;
  logic [31:0] rx_words [PayloadWords];

  frame_result_t pending_frames[$];

  int  errors = 0;
  int  frames_sent = 0;
  int  frames_seen = 0;
  int  framed_bytes = 0;
  int  input_stalls = 0;
  bit  src_gapless = 1'b0;
  bit  hold_off_req = 1'b0;
  bit  snk_calm = 1'b0;

  string word_name [PayloadWords] = '{"gyro_x", "gyro_y", "gyro_z", "accel_x", "accel_y",
                                      "accel_z", "speed_x", "speed_y", "turn_rate"};

  frame_row_t dir_plan [10] = '{
    '{3'd3, FillZero,   CrcKeep,    TailByte, 1'b1, StatusGood},     // first frame after reset
    '{3'd0, FillOnes,   CrcKeep,    TailByte, 1'b1, StatusGood},
    '{3'd1, FillRamp,   CrcBadLow,  TailByte, 1'b1, StatusCrcBad},
    '{3'd0, FillRamp,   CrcBadHigh, TailByte, 1'b1, StatusCrcBad},
    '{3'd2, FillHeader, CrcKeep,    8'h00,    1'b1, StatusTailBad},  // headers as payload
    '{3'd0, FillTail,   CrcBadBoth, 8'hFF,    1'b1, StatusBothBad},
    '{3'd0, FillRandom, CrcKeep,    TailByte, 1'b0, StatusGood},
    '{3'd5, FillRandom, CrcBadLow,  HeaderByte, 1'b1, StatusBothBad},
    '{3'd0, FillRandom, CrcKeep,    8'hB3,    1'b1, StatusTailBad},
    '{3'd0, FillRamp,   CrcKeep,    TailByte, 1'b0, StatusGood}
  };

  // Advance a reflected CRC-16 by one byte, bit by bit.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] t;
    t = {8'h00, crc[7:0] ^ b};
    for (int i = 0; i < 8; i++) begin
      t = t[0] ? ((t >> 1) ^ crc_poly) : (t >> 1);
    end
    return (crc >> 8) ^ t;
  endfunction

  // Feed one accepted byte to the model; return 1 when it closes a frame.
  function automatic bit deframe_byte(input logic [7:0] b, output frame_result_t res);
    int rel;
    res = '0;
    if (rx_pos == PosHunt) begin
      if (b == HeaderByte) begin
        rx_crc = crc_byte(crc_seed, b);
        rx_pos = rx_pos + 6'd1;
      end
      return 1'b0;
    end
    if (rx_pos <= PosLastPay) begin
      rel = int'(rx_pos) - 1;
      rx_words[rel / 4][(rel % 4) * 8 +: 8] = b;
      rx_crc = crc_byte(rx_crc, b);
      rx_pos = rx_pos + 6'd1;
      return 1'b0;
    end
    if (rx_pos == PosCrcLow) begin
      rx_crc_low = b;
      rx_pos = rx_pos + 6'd1;
      return 1'b0;
    end
    if (rx_pos == PosCrcHigh) begin
      rx_crc_bad = (rx_crc_low != rx_crc[7:0]) || (b != rx_crc[15:8]);
      rx_pos = rx_pos + 6'd1;
      return 1'b0;
    end
    // Tail byte: close the frame, gyro and accel x,y leave with the sign flipped
    res.status = (rx_crc_bad ? StatusCrcBad : StatusGood) |
                 ((b != TailByte) ? StatusTailBad : StatusGood);
    for (int k = 0; k < PayloadWords; k++) begin
      res.words[k] = rx_words[k] ^ ((k inside {0, 1, 3, 4}) ? 32'h8000_0000 : 32'h0);
    end
    rx_pos = PosHunt;
    rx_crc_bad = 1'b0;
    return 1'b1;
  endfunction

  function automatic int unsigned draw_gap();
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 19);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    if (errors <= MaxPrint) begin
      $display("[%0t] mismatch on %s: got %h, want %h", $time, what, got, want);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Offer one byte, hold it until taken, then run it through the model.
  // A forced status replaces the model's status for hand-typed rows.
  task automatic put_byte(input logic [7:0] b, input int forced_status);
    int unsigned   gap;
    frame_result_t res;
    gap = src_gapless ? 0 : draw_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    if (rx_pos != PosHunt || b == HeaderByte) framed_bytes++;
    if (deframe_byte(b, res)) begin
      if (forced_status >= 0) res.status = forced_status[1:0];
      pending_frames.push_back(res);
      frames_sent++;
    end
  endtask

  // Bytes seen while hunting; never the header.
  task automatic put_noise(input int unsigned n, input bit extremes);
    logic [7:0] b;
    for (int k = 0; k < n; k++) begin
      if (extremes && k == 0) b = 8'h00;
      else if (extremes && k == 1) b = 8'hFF;
      else begin
        do b = 8'($urandom); while (b == HeaderByte);
      end
      put_byte(b, -1);
    end
  endtask

  // Build and send a header-to-tail frame; the CRC is worked out under the
  // current settings, then damaged as asked.
  task automatic put_frame(input fill_e fill, input crc_fault_e fault,
                           input logic [7:0] tail, input int forced_status);
    logic [7:0]  body [36];
    logic [15:0] crc;
    crc = crc_byte(crc_seed, HeaderByte);
    for (int i = 0; i < 36; i++) begin
      case (fill)
        FillZero:   body[i] = 8'h00;
        FillOnes:   body[i] = 8'hFF;
        FillRamp:   body[i] = 8'(i * 7 + 1);
        FillHeader: body[i] = HeaderByte;
        FillTail:   body[i] = TailByte;
        default: begin
          // salt random payload with header and tail values now and then
          case ($urandom_range(0, 15))
            0:       body[i] = HeaderByte;
            1:       body[i] = TailByte;
            default: body[i] = 8'($urandom);
          endcase
        end
      endcase
      crc = crc_byte(crc, body[i]);
    end
    if (fault == CrcBadLow || fault == CrcBadBoth) crc[7:0] = ~crc[7:0];
    if (fault == CrcBadHigh || fault == CrcBadBoth) crc[15:8] = ~crc[15:8];
    put_byte(HeaderByte, -1);
    for (int i = 0; i < 36; i++) put_byte(body[i], -1);
    put_byte(crc[7:0], -1);
    put_byte(crc[15:8], -1);
    put_byte(tail, forced_status);
  endtask

  // Mostly clean frames with random content; some damaged, some pure noise.
  task automatic put_random_frames(input int unsigned n);
    int unsigned kind;
    for (int f = 0; f < n; f++) begin
      src_gapless = src_gapless | ($urandom_range(0, 3) == 0);
      put_noise(($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 4), 1'b0);
      kind = $urandom_range(0, 9);
      if (kind <= 5) put_frame(FillRandom, CrcKeep, TailByte, -1);
      else if (kind == 6) put_frame(FillRandom, crc_fault_e'($urandom_range(1, 3)), TailByte, -1);
      else if (kind == 7) put_frame(FillRandom, CrcKeep, 8'($urandom), -1);
      else if (kind == 8) put_frame(FillRandom, crc_fault_e'($urandom_range(0, 3)),
                                    8'($urandom), -1);
      else begin
        // broken frame: header followed by pure noise, CRC and tail included
        put_byte(HeaderByte, -1);
        repeat (39) put_byte(8'($urandom), -1);
      end
      if (!hold_off_req) src_gapless = 1'b0;
    end
  endtask

  // Drop valid and wait until every frame has been delivered, then let the
  // pipeline settle before touching the registers.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write both registers on back-to-back edges, then drop the write enable.
  task automatic program_crc(input logic [15:0] poly, input logic [15:0] init);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CfgIdxPoly;
    cfg_wdata_i <= poly;
    @(posedge clk_i);
    cfg_index_i <= CfgIdxInit;
    cfg_wdata_i <= init;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    crc_poly = poly;
    crc_seed = init;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: random ready gaps, one long hold-off on request
  // ---------------------------------------------------------------------------
  task automatic check_frame(input logic [OutDataBits-1:0] data);
    frame_result_t got;
    frame_result_t want;
    got = data[ResBits-1:0];
    frames_seen++;
    if (pending_frames.size() == 0) begin
      report_mismatch("unexpected frame word", 32'(got.status), 32'h0);
      return;
    end
    want = pending_frames.pop_front();
    if (got.status !== want.status) begin
      report_mismatch("frame_status", 32'(got.status), 32'(want.status));
    end
    for (int k = 0; k < PayloadWords; k++) begin
      if (got.words[k] !== want.words[k]) begin
        report_mismatch(word_name[k], got.words[k], want.words[k]);
      end
    end
    if (data[OutDataBits-1:ResBits] !== '0) begin
      report_mismatch("zero pad", 32'(data[OutDataBits-1:ResBits]), 32'h0);
    end
  endtask

  initial begin : frame_sink
    int unsigned gap;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        // hold ready low long enough for the core to fill and stall its input
        m_axis_tready <= 1'b0;
        repeat (HoldOff) @(posedge clk_i);
        hold_off_req = 1'b0;
      end
      if ($urandom_range(0, 7) == 0) snk_calm = ~snk_calm;
      gap = snk_calm ? 0 : draw_gap();
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      check_frame(m_axis_tdata);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && !s_axis_tready) input_stalls++;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : byte_source
    for (int k = 0; k < PayloadWords; k++) rx_words[k] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames under the reset settings
    foreach (dir_plan[r]) begin
      put_noise(dir_plan[r].lead, 1'b1);
      put_frame(dir_plan[r].fill, dir_plan[r].fault, dir_plan[r].tail,
                dir_plan[r].typed ? int'(dir_plan[r].status) : -1);
    end
    drain();

    // Extreme settings: all zeros, then all ones
    program_crc(16'h0000, 16'h0000);
    put_random_frames(4);
    drain();
    program_crc(16'hFFFF, 16'hFFFF);
    put_random_frames(4);

    // Leave a frame half received, retune, then finish it: the polynomial
    // applies to the remaining bytes, the start value only to the next header
    put_byte(HeaderByte, -1);
    repeat (15) put_byte(8'($urandom), -1);
    drain();
    program_crc(16'hA001, 16'h1D0F);
    repeat (23) put_byte(8'($urandom), -1);
    put_byte(($urandom_range(0, 1) == 0) ? TailByte : 8'($urandom), -1);
    put_random_frames(4);
    drain();

    // Random settings with a long receiver hold-off against back-to-back frames
    program_crc(16'($urandom), 16'($urandom));
    hold_off_req = 1'b1;
    src_gapless  = 1'b1;
    put_random_frames(4);
    src_gapless = 1'b0;
    put_random_frames(2);
    drain();

    // Back to the reset values
    program_crc(PolyReset, InitReset);
    put_random_frames(4);
    drain();
    repeat (20) @(posedge clk_i);

    $display("Run covered %0d frames (%0d framed bytes) over six CRC settings,",
             frames_seen, framed_bytes);
    $display("with %0d input stall cycles under receiver back-pressure.", input_stalls);
    if (errors == 0 && frames_seen == frames_sent) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : watchdog
    #3_000_000;
    $display("Timeout with %0d frames outstanding", pending_frames.size());
    $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
hdl/sfr_pkg.sv
hdl/sfr_crc_step.sv
hdl/sfr_deframer.sv
hdl/sfr_out_reg.sv
hdl/sensor_frame_receiver_crc16_core.sv
sim/tb_sensor_frame_receiver_crc16_core.sv
